// ===== hw/rtl/adlbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adlbd_pkg
// Shared types, constants and the ladder window decode for the keypad
// debouncer.
// ----------------------------------------------------------------------------
package adlbd_pkg;

   localparam int TIME_BITS   = 32;
   localparam int NUM_BUTTONS = 5;

   localparam int SAMPLE_BITS   = 12;
   localparam int NOW_BITS      = 32;
   localparam int DEBOUNCE_BITS = 16;
   localparam int HOLD_BITS     = 32;

   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 32;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // ladder window limits (open intervals)
   localparam logic [SAMPLE_BITS-1:0] WIN0_HI = 12'd200;
   localparam logic [SAMPLE_BITS-1:0] WIN1_LO = 12'd700;
   localparam logic [SAMPLE_BITS-1:0] WIN1_HI = 12'd1100;
   localparam logic [SAMPLE_BITS-1:0] WIN2_LO = 12'd1300;
   localparam logic [SAMPLE_BITS-1:0] WIN2_HI = 12'd1700;
   localparam logic [SAMPLE_BITS-1:0] WIN3_LO = 12'd1900;
   localparam logic [SAMPLE_BITS-1:0] WIN3_HI = 12'd2300;
   localparam logic [SAMPLE_BITS-1:0] WIN4_LO = 12'd2700;
   localparam logic [SAMPLE_BITS-1:0] WIN4_HI = 12'd3100;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERT   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD     = 2'd2;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd25;
   localparam logic [NUM_BUTTONS-1:0]   INVERT_RESET   = 5'd31;
   localparam logic [HOLD_BITS-1:0]     HOLD_RESET     = 32'd1000;

   typedef logic [TIME_BITS-1:0]   time_type;
   typedef logic [NUM_BUTTONS-1:0] btn_mask_type;

   // classified word handed from front to back
   typedef struct packed {
      btn_mask_type raw;
      time_type     now;
   } item_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   // bit i set when the sample lies inside button i's window
   function automatic btn_mask_type window_hits(input logic [SAMPLE_BITS-1:0] s);
      btn_mask_type m;
      m    = '0;
      m[0] = (s < WIN0_HI);
      m[1] = (s > WIN1_LO) && (s < WIN1_HI);
      m[2] = (s > WIN2_LO) && (s < WIN2_HI);
      m[3] = (s > WIN3_LO) && (s < WIN3_HI);
      m[4] = (s > WIN4_LO) && (s < WIN4_HI);
      return m;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/adlbd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adlbd_front
// Input side: accept sample words and decode the ladder voltage into a raw
// per-button level.
// ----------------------------------------------------------------------------
module adlbd_front (
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [adlbd_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  wire logic [adlbd_pkg::NUM_BUTTONS-1:0]     invert_mask,
   input  wire adlbd_pkg::queue_status_type           q_status,
   output logic                                       q_push,
   output adlbd_pkg::item_type                        q_item
);

   logic [adlbd_pkg::SAMPLE_BITS-1:0] sample;
   logic [adlbd_pkg::NOW_BITS-1:0]    now_full;

   assign sample   = req_tdata[adlbd_pkg::SAMPLE_BITS-1:0];
   assign now_full = req_tdata[adlbd_pkg::SAMPLE_BITS +: adlbd_pkg::NOW_BITS];

   // take a word whenever the queue has room
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && !q_status.full;

   // in-window reads low; invert flips to pressed-high
   assign q_item.raw = (~adlbd_pkg::window_hits(sample)) ^ invert_mask;
   assign q_item.now = adlbd_pkg::TIME_BITS'(now_full);

endmodule
`default_nettype wire

// ===== hw/rtl/adlbd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adlbd_queue
// Short FIFO between the decode front and the debounce back.
// ----------------------------------------------------------------------------
module adlbd_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire adlbd_pkg::item_type         push_item,
   input  wire logic                        pop,
   output adlbd_pkg::item_type              pop_item,
   output adlbd_pkg::queue_status_type      status
);

   adlbd_pkg::item_type entry_ff [adlbd_pkg::QUEUE_DEPTH];

   logic [adlbd_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [adlbd_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [adlbd_pkg::QPTR_BITS:0]   count_ff, count_in;

   function automatic logic [adlbd_pkg::QPTR_BITS-1:0] next_ptr(
      input logic [adlbd_pkg::QPTR_BITS-1:0] p);
      logic [adlbd_pkg::QPTR_BITS-1:0] n;
      if (p == adlbd_pkg::QPTR_BITS'(adlbd_pkg::QUEUE_DEPTH - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (adlbd_pkg::QPTR_BITS+1)'(push)
                           - (adlbd_pkg::QPTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item         = entry_ff[rd_ptr_ff];
   assign status.full      = (count_ff == (adlbd_pkg::QPTR_BITS+1)'(adlbd_pkg::QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule
`default_nettype wire

// ===== hw/rtl/adlbd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adlbd_back
// Debounce engine: per-button level and change time, edge and hold flags,
// and the registered result word.
// ----------------------------------------------------------------------------
module adlbd_back (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire adlbd_pkg::queue_status_type            q_status,
   input  wire adlbd_pkg::item_type                    q_item,
   output logic                                        q_pop,
   input  wire logic [adlbd_pkg::DEBOUNCE_BITS-1:0]    debounce_ms,
   input  wire logic [adlbd_pkg::HOLD_BITS-1:0]        hold_ms,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [adlbd_pkg::RSP_DATA_BITS-1:0]         rsp_tdata
);

   localparam int NB = adlbd_pkg::NUM_BUTTONS;

   adlbd_pkg::time_type     last_change_ff [NB];
   adlbd_pkg::time_type     last_change_in [NB];
   adlbd_pkg::time_type     elapsed        [NB];
   adlbd_pkg::time_type     elapsed_hold   [NB];
   adlbd_pkg::btn_mask_type level_ff, level_in;
   logic                    primed_ff;
   adlbd_pkg::btn_mask_type rise, fall, held, idle;

   logic                    out_valid_ff;
   adlbd_pkg::btn_mask_type state_ff, pressed_ff, released_ff, held_ff, idle_ff;

   // advance when the output register is free or being drained
   assign q_pop = q_status.not_empty && (!out_valid_ff || rsp_tready);

   always_comb begin
      level_in = level_ff;
      rise     = '0;
      fall     = '0;
      held     = '0;
      idle     = '0;
      for (int i = 0; i < NB; i++) begin
         elapsed[i]        = q_item.now - last_change_ff[i];
         last_change_in[i] = last_change_ff[i];
         elapsed_hold[i]   = elapsed[i];
         if (!primed_ff) begin
            // prime: load level and time, no edges
            level_in[i]       = q_item.raw[i];
            last_change_in[i] = q_item.now;
            elapsed_hold[i]   = '0;
         end else if ((elapsed[i] >= adlbd_pkg::TIME_BITS'(debounce_ms)) &&
                      (q_item.raw[i] != level_ff[i])) begin
            level_in[i]       = q_item.raw[i];
            last_change_in[i] = q_item.now;
            elapsed_hold[i]   = '0;
            rise[i]           = q_item.raw[i];
            fall[i]           = !q_item.raw[i];
         end
         if (adlbd_pkg::HOLD_BITS'(elapsed_hold[i]) >= hold_ms) begin
            held[i] = level_in[i];
            idle[i] = !level_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         primed_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            level_ff  <= level_in;
            primed_ff <= 1'b1;
         end
         if (q_pop) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         for (int i = 0; i < NB; i++) begin
            last_change_ff[i] <= last_change_in[i];
         end
         state_ff    <= level_in;
         pressed_ff  <= rise;
         released_ff <= fall;
         held_ff     <= held;
         idle_ff     <= idle;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = adlbd_pkg::RSP_DATA_BITS'({idle_ff, held_ff, released_ff,
                                                  pressed_ff, state_ff});

endmodule
`default_nettype wire

// ===== hw/rtl/adc_ladder_button_debouncer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A sample word passes through the queue and the result register in turn.
// Throughput: one sample word per cycle while rsp_tready is high; the debounce
// update is registered straight into the result word, and a two-entry queue
// keeps the input open, until it fills, while a result waits on rsp_tready.
// Reset (synchronous, active high): clears the queue, the result valid flag, the
// debounced levels and the primed flag, and loads debounce 25, invert 31, hold 1000.
// ----------------------------------------------------------------------------
// adc_ladder_button_debouncer_unit
// Five-button resistor-ladder keypad decoder with per-button debounce, edge
// detection and held/idle flags.
// ----------------------------------------------------------------------------
module adc_ladder_button_debouncer_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // sample channel
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // [11:0] adc_sample, [43:12] now_ms, [47:44] zero
   input  wire logic [adlbd_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // result channel
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [4:0] state_mask, [9:5] pressed_edge_mask, [14:10] released_edge_mask,
   // [19:15] held_mask, [24:20] idle_mask, [31:25] zero
   output logic [adlbd_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,
   // register write channel
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [adlbd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [adlbd_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are registered; an index past the list
   // is taken and dropped.
   // ---------------------------------------------------------------------
   logic [adlbd_pkg::DEBOUNCE_BITS-1:0] debounce_ms_ff;
   logic [adlbd_pkg::NUM_BUTTONS-1:0]   invert_mask_ff;
   logic [adlbd_pkg::HOLD_BITS-1:0]     hold_ms_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= adlbd_pkg::DEBOUNCE_RESET;
         invert_mask_ff <= adlbd_pkg::INVERT_RESET;
         hold_ms_ff     <= adlbd_pkg::HOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            adlbd_pkg::CSR_DEBOUNCE: begin
               debounce_ms_ff <= csr_data[adlbd_pkg::DEBOUNCE_BITS-1:0];
            end
            adlbd_pkg::CSR_INVERT: begin
               invert_mask_ff <= csr_data[adlbd_pkg::NUM_BUTTONS-1:0];
            end
            adlbd_pkg::CSR_HOLD: begin
               hold_ms_ff <= csr_data[adlbd_pkg::HOLD_BITS-1:0];
            end
            default: begin
               // unmapped index: drop the word
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Front: decode the ladder sample into raw levels and push to the queue.
   // ---------------------------------------------------------------------
   adlbd_pkg::queue_status_type q_status;
   adlbd_pkg::item_type         push_item;
   adlbd_pkg::item_type         pop_item;
   logic                        q_push;
   logic                        q_pop;

   adlbd_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .invert_mask (invert_mask_ff),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   // Queue: decouple the decode from the debounce engine.
   adlbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // Back: debounce, edges, hold flags and the result register.
   adlbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_item      (pop_item),
      .q_pop       (q_pop),
      .debounce_ms (debounce_ms_ff),
      .hold_ms     (hold_ms_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // ---------------------------------------------------------------------
   // Checks on the result word: edges and flags agree with the state.
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   a_press_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[9:5] & ~rsp_tdata[4:0]) == 5'd0))
      else $error("pressed edge on a button whose state is zero");

   a_release_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[14:10] & rsp_tdata[4:0]) == 5'd0))
      else $error("released edge on a button whose state is one");

   a_hold_idle_match_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (((rsp_tdata[19:15] & ~rsp_tdata[4:0]) == 5'd0) &&
                      ((rsp_tdata[24:20] & rsp_tdata[4:0]) == 5'd0)))
      else $error("held or idle flag disagrees with the state");
`endif

endmodule
`default_nettype wire
